// ----- rtl/i2cseq_pkg.sv -----
// Package with the shared types, codes and constants of the I2C register access sequencer.
package i2cseq_pkg;

    // Request and controller event codes. Code 7 is an unknown status.
    typedef enum logic [2:0] {
        ACT_WRITE         = 3'd0,
        ACT_READ          = 3'd1,
        ACT_START_SENT    = 3'd2,
        ACT_BYTE_SENT     = 3'd3,
        ACT_BYTE_RECEIVED = 3'd4,
        ACT_OTHER_STATUS  = 3'd5,
        ACT_RESET         = 3'd6
    } t_action;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_WIDE_DEVICE_ONE   = 2'd0,
        CFG_WIDE_DEVICE_TWO   = 2'd1,
        CFG_WIDE_DEVICE_THREE = 2'd2
    } t_cfg_index;

    // Mask that clears the direction bit of a device address byte.
    localparam logic [7:0] ADDR_DIR_MASK = 8'hFE;

    // Offset byte count at which the high offset byte goes out, and the low one.
    localparam logic [1:0] OFFS_HIGH_SENT = 2'd1;
    localparam logic [1:0] OFFS_LOW_SENT  = 2'd2;

    // One accepted request or controller event.
    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  device_address;
        logic [15:0] offset_address;
        logic [15:0] transfer_length;
        logic        ack_received;
        logic        arbitration_lost;
        logic [7:0]  received_byte;
        logic [7:0]  next_write_byte;
    } t_event;

    // One result, produced for every event.
    typedef struct packed {
        logic        transmit_valid;
        logic [7:0]  transmit_byte;
        logic        issue_start;
        logic        issue_stop;
        logic        ack_to_send;
        logic        store_valid;
        logic [7:0]  store_byte;
        logic [15:0] data_index;
        logic        busy_now;
        logic        transfer_failed;
        logic        request_rejected;
    } t_result;

    // Device addresses that take a two-byte offset.
    typedef struct packed {
        logic [7:0] wide_one;
        logic [7:0] wide_two;
        logic [7:0] wide_three;
    } t_wide_cfg;

endpackage

// ----- rtl/i2cseq_cfg_regs.sv -----
// Configuration registers holding the three wide-offset device addresses.
module i2cseq_cfg_regs (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [1:0]            i_cfg_index,
    input  logic [7:0]            i_cfg_data,
    output i2cseq_pkg::t_wide_cfg o_wide_cfg
);
    import i2cseq_pkg::*;

    t_wide_cfg r_wide_cfg;

    // Writes to an index beyond the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_WIDE_DEVICE_ONE:   r_wide_cfg.wide_one   <= i_cfg_data;
                CFG_WIDE_DEVICE_TWO:   r_wide_cfg.wide_two   <= i_cfg_data;
                CFG_WIDE_DEVICE_THREE: r_wide_cfg.wide_three <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_wide_cfg = r_wide_cfg;

endmodule

// ----- rtl/i2cseq_in_stage.sv -----
// Input register that holds one accepted request or event until the core takes it.
module i2cseq_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  i2cseq_pkg::t_event i_event,
    input  logic               i_advance,
    output logic               o_fire,
    output i2cseq_pkg::t_event o_event
);
    import i2cseq_pkg::*;

    logic   r_valid;
    t_event r_event;
    logic   accept;

    // The stage stalls only while it is full and the core cannot move on.
    assign o_stall = r_valid && !i_advance;
    assign accept  = i_valid && !o_stall;
    assign o_fire  = r_valid && i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_event <= i_event;
        end
    end

    assign o_event = r_event;

endmodule

// ----- rtl/i2cseq_core.sv -----
// Transfer state and the single-pass logic that turns one event into one result.
module i2cseq_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  i2cseq_pkg::t_event    i_event,
    input  i2cseq_pkg::t_wide_cfg i_wide_cfg,
    output i2cseq_pkg::t_result   o_result
);
    import i2cseq_pkg::*;

    // Transfer state.
    logic        r_busy,            n_busy;
    logic [7:0]  r_target_address,  n_target_address;
    logic [15:0] r_register_offset, n_register_offset;
    logic [15:0] r_length_total,    n_length_total;
    logic [15:0] r_byte_counter,    n_byte_counter;
    logic        r_read_direction,  n_read_direction;
    logic        r_offset_pending,  n_offset_pending;
    logic        r_turn_to_read,    n_turn_to_read;
    logic        r_restart_pending, n_restart_pending;
    logic        r_retry_on_nack,   n_retry_on_nack;
    logic        r_wide_offset,     n_wide_offset;
    logic [1:0]  r_offset_sent,     n_offset_sent;

    t_result res;
    logic    fail;
    logic    last_offset;
    logic    wide_match;
    logic [15:0] counter_inc;

    assign wide_match = (i_event.device_address == i_wide_cfg.wide_one)
                     || (i_event.device_address == i_wide_cfg.wide_two)
                     || (i_event.device_address == i_wide_cfg.wide_three);
    assign counter_inc = r_byte_counter + 16'd1;

    // Next state and result for the event at the head of the input stage.
    always_comb begin
        n_busy            = r_busy;
        n_target_address  = r_target_address;
        n_register_offset = r_register_offset;
        n_length_total    = r_length_total;
        n_byte_counter    = r_byte_counter;
        n_read_direction  = r_read_direction;
        n_offset_pending  = r_offset_pending;
        n_turn_to_read    = r_turn_to_read;
        n_restart_pending = r_restart_pending;
        n_retry_on_nack   = r_retry_on_nack;
        n_wide_offset     = r_wide_offset;
        n_offset_sent     = r_offset_sent;
        res               = '0;
        fail              = 1'b0;
        last_offset       = 1'b0;

        unique case (t_action'(i_event.action))
            ACT_WRITE, ACT_READ: begin
                // A request is refused while busy or when it moves no data.
                if (r_busy || (i_event.transfer_length == '0)) begin
                    res.request_rejected = 1'b1;
                end else begin
                    n_busy            = 1'b1;
                    n_target_address  = i_event.device_address;
                    n_register_offset = i_event.offset_address;
                    n_length_total    = i_event.transfer_length;
                    n_read_direction  = 1'b0;
                    n_offset_pending  = 1'b1;
                    n_turn_to_read    = (t_action'(i_event.action) == ACT_READ);
                    n_restart_pending = 1'b0;
                    n_retry_on_nack   = 1'b1;
                    n_offset_sent     = '0;
                    n_wide_offset     = wide_match;
                    res.issue_start   = 1'b1;
                end
            end
            ACT_RESET: begin
                n_busy              = 1'b0;
                n_retry_on_nack     = 1'b0;
                res.transfer_failed = 1'b1;
            end
            ACT_START_SENT: begin
                // Address byte with the current direction bit.
                if (i_event.arbitration_lost) begin
                    fail = 1'b1;
                end else begin
                    res.transmit_valid = 1'b1;
                    res.transmit_byte  = (r_target_address & ADDR_DIR_MASK)
                                       | {7'd0, r_read_direction};
                    n_byte_counter     = '0;
                end
            end
            ACT_BYTE_SENT: begin
                if (i_event.arbitration_lost) begin
                    fail = 1'b1;
                end else if (!i_event.ack_received) begin
                    if (r_retry_on_nack) begin
                        res.issue_start = 1'b1;
                    end else begin
                        fail = 1'b1;
                    end
                end else if (r_restart_pending) begin
                    res.issue_start   = 1'b1;
                    n_restart_pending = 1'b0;
                end else if (r_offset_pending) begin
                    // Wide devices take the high offset byte first.
                    if (!r_wide_offset) begin
                        last_offset = 1'b1;
                    end else begin
                        n_offset_sent = r_offset_sent + 2'd1;
                        if (n_offset_sent == OFFS_HIGH_SENT) begin
                            res.transmit_valid = 1'b1;
                            res.transmit_byte  = r_register_offset[15:8];
                        end else if (n_offset_sent == OFFS_LOW_SENT) begin
                            n_offset_sent = '0;
                            last_offset   = 1'b1;
                        end
                    end
                    if (last_offset) begin
                        n_offset_pending   = 1'b0;
                        res.transmit_valid = 1'b1;
                        res.transmit_byte  = r_register_offset[7:0];
                        if (r_turn_to_read) begin
                            n_restart_pending = 1'b1;
                            n_read_direction  = 1'b1;
                        end
                    end
                end else if (!r_read_direction) begin
                    // Write data phase: stream bytes, then stop.
                    if (r_byte_counter < r_length_total) begin
                        res.transmit_valid = 1'b1;
                        res.transmit_byte  = i_event.next_write_byte;
                        res.data_index     = r_byte_counter;
                        n_byte_counter     = counter_inc;
                    end else begin
                        res.issue_stop = 1'b1;
                        n_busy         = 1'b0;
                    end
                end
            end
            ACT_BYTE_RECEIVED: begin
                // Acknowledge every byte but the last, which ends with a stop.
                if (i_event.arbitration_lost) begin
                    fail = 1'b1;
                end else begin
                    res.store_valid = 1'b1;
                    res.store_byte  = i_event.received_byte;
                    res.data_index  = r_byte_counter;
                    n_byte_counter  = counter_inc;
                    if (counter_inc < r_length_total) begin
                        res.ack_to_send = 1'b1;
                    end else begin
                        res.issue_stop = 1'b1;
                        n_busy         = 1'b0;
                    end
                end
            end
            default: begin
                fail = 1'b1;
            end
        endcase

        // A failure drops the transfer and withdraws every bus request.
        if (fail) begin
            n_busy              = 1'b0;
            n_retry_on_nack     = 1'b0;
            res.transfer_failed = 1'b1;
            res.issue_start     = 1'b0;
            res.issue_stop      = 1'b0;
            res.ack_to_send     = 1'b0;
        end

        res.busy_now = n_busy;
    end

    // State advances once for every event taken from the input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy            <= 1'b0;
            r_target_address  <= '0;
            r_register_offset <= '0;
            r_length_total    <= '0;
            r_byte_counter    <= '0;
            r_read_direction  <= 1'b0;
            r_offset_pending  <= 1'b0;
            r_turn_to_read    <= 1'b0;
            r_restart_pending <= 1'b0;
            r_retry_on_nack   <= 1'b0;
            r_wide_offset     <= 1'b0;
            r_offset_sent     <= '0;
        end else if (i_fire) begin
            r_busy            <= n_busy;
            r_target_address  <= n_target_address;
            r_register_offset <= n_register_offset;
            r_length_total    <= n_length_total;
            r_byte_counter    <= n_byte_counter;
            r_read_direction  <= n_read_direction;
            r_offset_pending  <= n_offset_pending;
            r_turn_to_read    <= n_turn_to_read;
            r_restart_pending <= n_restart_pending;
            r_retry_on_nack   <= n_retry_on_nack;
            r_wide_offset     <= n_wide_offset;
            r_offset_sent     <= n_offset_sent;
        end
    end

    assign o_result = res;

endmodule

// ----- rtl/i2cseq_out_stage.sv -----
// Result register that holds one result until the receiving side takes it.
module i2cseq_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  i2cseq_pkg::t_result i_result,
    input  logic                i_stall,
    output logic                o_free,
    output logic                o_valid,
    output i2cseq_pkg::t_result o_result
);
    import i2cseq_pkg::*;

    logic    r_valid;
    t_result r_result;

    // The register can take a new result when empty or being emptied.
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- rtl/i2c_master_register_access_sequencer_top.sv -----
// Top level of the I2C master register access sequencer.
// The block takes one request or controller event per clock cycle unless a stall holds it, and
// returns exactly one result for each: the event is captured in an input register, the
// transfer state and the result are worked out in one pass of logic, and the result sits
// in an output register until the receiving side takes it. The rate is set by that single
// pass through the core, which updates the transfer state once per event. Configuration
// writes are always ready and should be made while no event is in flight.
module i2c_master_register_access_sequencer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request and event channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_device_address,
    input  logic [15:0] i_offset_address,
    input  logic [15:0] i_transfer_length,
    input  logic        i_ack_received,
    input  logic        i_arbitration_lost,
    input  logic [7:0]  i_received_byte,
    input  logic [7:0]  i_next_write_byte,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_transmit_valid,
    output logic [7:0]  o_transmit_byte,
    output logic        o_issue_start,
    output logic        o_issue_stop,
    output logic        o_ack_to_send,
    output logic        o_store_valid,
    output logic [7:0]  o_store_byte,
    output logic [15:0] o_data_index,
    output logic        o_busy_now,
    output logic        o_transfer_failed,
    output logic        o_request_rejected,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import i2cseq_pkg::*;

    t_event    in_event;
    t_event    head_event;
    t_result   core_result;
    t_result   out_result;
    t_wide_cfg wide_cfg;
    logic      fire;
    logic      out_free;

    assign o_cfg_ready = 1'b1;

    // Gather the request fields into one event.
    always_comb begin
        in_event.action           = i_action;
        in_event.device_address   = i_device_address;
        in_event.offset_address   = i_offset_address;
        in_event.transfer_length  = i_transfer_length;
        in_event.ack_received     = i_ack_received;
        in_event.arbitration_lost = i_arbitration_lost;
        in_event.received_byte    = i_received_byte;
        in_event.next_write_byte  = i_next_write_byte;
    end

    i2cseq_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_wide_cfg  (wide_cfg)
    );

    i2cseq_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_event   (in_event),
        .i_advance (out_free),
        .o_fire    (fire),
        .o_event   (head_event)
    );

    i2cseq_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_event    (head_event),
        .i_wide_cfg (wide_cfg),
        .o_result   (core_result)
    );

    i2cseq_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_result (core_result),
        .i_stall  (i_out_stall),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    // Unpack the held result onto the output ports.
    assign o_transmit_valid   = out_result.transmit_valid;
    assign o_transmit_byte    = out_result.transmit_byte;
    assign o_issue_start      = out_result.issue_start;
    assign o_issue_stop       = out_result.issue_stop;
    assign o_ack_to_send      = out_result.ack_to_send;
    assign o_store_valid      = out_result.store_valid;
    assign o_store_byte       = out_result.store_byte;
    assign o_data_index       = out_result.data_index;
    assign o_busy_now         = out_result.busy_now;
    assign o_transfer_failed  = out_result.transfer_failed;
    assign o_request_rejected = out_result.request_rejected;

endmodule

// ----- rtl/i2cseq_checker.sv -----
// Port-level checker for the I2C register access sequencer, bound to the top level.
module i2cseq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_transmit_valid,
    input logic [7:0]  o_transmit_byte,
    input logic        o_issue_start,
    input logic        o_issue_stop,
    input logic        o_ack_to_send,
    input logic        o_store_valid,
    input logic [7:0]  o_store_byte,
    input logic [15:0] o_data_index,
    input logic        o_busy_now,
    input logic        o_transfer_failed,
    input logic        o_request_rejected
);

    // A stalled result stays presented and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_data_index)
            && $stable(o_transmit_byte) && $stable(o_store_byte))
        else $error("stalled result changed");

    // A failed transfer leaves the block idle with no bus request.
    a_fail_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_transfer_failed |->
            !o_busy_now && !o_issue_start && !o_issue_stop && !o_ack_to_send)
        else $error("failure result carries a bus request");

    // A result never both transmits and stores a byte.
    a_tx_or_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_transmit_valid && o_store_valid))
        else $error("transmit and store in one result");

    // A rejected request changes nothing on the bus.
    a_reject_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_request_rejected |->
            !o_issue_start && !o_transmit_valid && !o_store_valid && !o_transfer_failed)
        else $error("rejected request acted on the bus");

    // A stop ends the transfer and sends no acknowledge.
    a_stop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_issue_stop |-> !o_busy_now && !o_ack_to_send)
        else $error("stop issued while still busy");

endmodule

bind i2c_master_register_access_sequencer_top i2cseq_checker u_i2cseq_checker (.*);

// ----- bench/tb.sv -----
// Self-checking bench for the I2C register access sequencer: random event traffic checked against a predictor.
module tb;
    import i2cseq_pkg::*;

    // Status code outside the known set; the block treats it as an unknown status.
    localparam logic [2:0] ACT_UNKNOWN_STATUS = 3'd7;

    localparam int PHASE_COUNT     = 6;
    localparam int PHASE_REQUESTS  = 325;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_AT     = 600;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 500000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_action = ACT_RESET;
    logic [7:0]  i_device_address = 8'd0;
    logic [15:0] i_offset_address = 16'd0;
    logic [15:0] i_transfer_length = 16'd0;
    logic        i_ack_received = 1'b0;
    logic        i_arbitration_lost = 1'b0;
    logic [7:0]  i_received_byte = 8'd0;
    logic [7:0]  i_next_write_byte = 8'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_transmit_valid;
    logic [7:0]  o_transmit_byte;
    logic        o_issue_start;
    logic        o_issue_stop;
    logic        o_ack_to_send;
    logic        o_store_valid;
    logic [7:0]  o_store_byte;
    logic [15:0] o_data_index;
    logic        o_busy_now;
    logic        o_transfer_failed;
    logic        o_request_rejected;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_WIDE_DEVICE_ONE;
    logic [7:0]  i_cfg_data = 8'd0;

    i2c_master_register_access_sequencer_top uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_action           (i_action),
        .i_device_address   (i_device_address),
        .i_offset_address   (i_offset_address),
        .i_transfer_length  (i_transfer_length),
        .i_ack_received     (i_ack_received),
        .i_arbitration_lost (i_arbitration_lost),
        .i_received_byte    (i_received_byte),
        .i_next_write_byte  (i_next_write_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_transmit_valid   (o_transmit_valid),
        .o_transmit_byte    (o_transmit_byte),
        .o_issue_start      (o_issue_start),
        .o_issue_stop       (o_issue_stop),
        .o_ack_to_send      (o_ack_to_send),
        .o_store_valid      (o_store_valid),
        .o_store_byte       (o_store_byte),
        .o_data_index       (o_data_index),
        .o_busy_now         (o_busy_now),
        .o_transfer_failed  (o_transfer_failed),
        .o_request_rejected (o_request_rejected),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Bench-side copy of the configuration and of the transfer state.
    t_wide_cfg   wide_cfg = '0;
    logic        xfer_busy = 1'b0;
    logic [7:0]  xfer_device = 8'd0;
    logic [15:0] xfer_offset = 16'd0;
    logic [15:0] xfer_length = 16'd0;
    logic [15:0] byte_count = 16'd0;
    logic        reading = 1'b0;
    logic        offset_owed = 1'b0;
    logic        read_after_offset = 1'b0;
    logic        restart_owed = 1'b0;
    logic        nack_retry = 1'b0;
    logic        offset_wide = 1'b0;
    logic [1:0]  offset_count = 2'd0;

    t_event      pending_events[$];
    t_result     expected_results[$];

    int          mismatch_count = 0;
    int          results_seen = 0;
    int          cycle_count = 0;
    bit          event_taken = 1'b0;
    int          send_wait = 0;
    int          send_mode = 0;
    int          stall_left = 0;
    int          recv_mode = 0;
    int          hold_off_left = 0;
    bit          hold_off_done = 1'b0;

    function automatic logic is_wide(input logic [7:0] dev);
        return dev == wide_cfg.wide_one || dev == wide_cfg.wide_two ||
               dev == wide_cfg.wide_three;
    endfunction

    // Works out the result of one request or controller event and advances the transfer state.
    function automatic t_result sequence_event(input t_event ev);
        t_result r;
        logic    abort_now;
        logic    offset_done;
        r = '0;
        abort_now = 1'b0;
        offset_done = 1'b0;
        case (ev.action)
            ACT_WRITE, ACT_READ: begin
                if (xfer_busy || ev.transfer_length == 16'd0) begin
                    r.request_rejected = 1'b1;
                end else begin
                    xfer_busy = 1'b1;
                    xfer_device = ev.device_address;
                    xfer_offset = ev.offset_address;
                    xfer_length = ev.transfer_length;
                    reading = 1'b0;
                    offset_owed = 1'b1;
                    read_after_offset = (ev.action == ACT_READ);
                    restart_owed = 1'b0;
                    nack_retry = 1'b1;
                    offset_count = 2'd0;
                    offset_wide = is_wide(ev.device_address);
                    r.issue_start = 1'b1;
                end
            end
            ACT_RESET: begin
                xfer_busy = 1'b0;
                nack_retry = 1'b0;
                r.transfer_failed = 1'b1;
            end
            default: begin
                if (ev.arbitration_lost) begin
                    abort_now = 1'b1;
                end else if (ev.action == ACT_START_SENT) begin
                    r.transmit_valid = 1'b1;
                    r.transmit_byte = (xfer_device & ADDR_DIR_MASK) | {7'd0, reading};
                    byte_count = 16'd0;
                end else if (ev.action == ACT_BYTE_SENT) begin
                    if (!ev.ack_received) begin
                        // A NACK starts the transfer again unless a failure has disarmed it.
                        if (nack_retry) begin
                            r.issue_start = 1'b1;
                        end else begin
                            abort_now = 1'b1;
                        end
                    end else if (restart_owed) begin
                        r.issue_start = 1'b1;
                        restart_owed = 1'b0;
                    end else if (offset_owed) begin
                        if (!offset_wide) begin
                            offset_done = 1'b1;
                        end else begin
                            offset_count = offset_count + 2'd1;
                            if (offset_count == OFFS_HIGH_SENT) begin
                                r.transmit_valid = 1'b1;
                                r.transmit_byte = xfer_offset[15:8];
                            end else if (offset_count == OFFS_LOW_SENT) begin
                                offset_count = 2'd0;
                                offset_done = 1'b1;
                            end
                        end
                        if (offset_done) begin
                            offset_owed = 1'b0;
                            r.transmit_valid = 1'b1;
                            r.transmit_byte = xfer_offset[7:0];
                            if (read_after_offset) begin
                                restart_owed = 1'b1;
                                reading = 1'b1;
                            end
                        end
                    end else if (!reading) begin
                        if (byte_count < xfer_length) begin
                            r.transmit_valid = 1'b1;
                            r.transmit_byte = ev.next_write_byte;
                            r.data_index = byte_count;
                            byte_count = byte_count + 16'd1;
                        end else begin
                            r.issue_stop = 1'b1;
                            xfer_busy = 1'b0;
                        end
                    end
                end else if (ev.action == ACT_BYTE_RECEIVED) begin
                    r.store_valid = 1'b1;
                    r.store_byte = ev.received_byte;
                    r.data_index = byte_count;
                    byte_count = byte_count + 16'd1;
                    if (byte_count < xfer_length) begin
                        r.ack_to_send = 1'b1;
                    end else begin
                        r.issue_stop = 1'b1;
                        xfer_busy = 1'b0;
                    end
                end else begin
                    abort_now = 1'b1;
                end
            end
        endcase
        // A failed transfer drops every bus request.
        if (abort_now) begin
            xfer_busy = 1'b0;
            nack_retry = 1'b0;
            r.transfer_failed = 1'b1;
            r.issue_start = 1'b0;
            r.issue_stop = 1'b0;
            r.ack_to_send = 1'b0;
        end
        r.busy_now = xfer_busy;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] seen);
        if (want !== seen) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
            mismatch_count++;
        end
    endfunction

    // Wait before the next request or result: none, occasional or constant idling.
    function automatic int pick_wait(input int mode);
        case (mode)
            0: return 0;
            1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
            default: return $urandom_range(0, 19);
        endcase
    endfunction

    function automatic t_event random_event();
        t_event ev;
        ev.action = 3'($urandom_range(0, 7));
        ev.device_address = 8'($urandom);
        ev.offset_address = 16'($urandom);
        ev.transfer_length = 16'($urandom);
        ev.ack_received = 1'($urandom);
        ev.arbitration_lost = 1'($urandom);
        ev.received_byte = 8'($urandom);
        ev.next_write_byte = 8'($urandom);
        return ev;
    endfunction

    function automatic t_event clean_event(input logic [2:0] act);
        t_event ev;
        ev = random_event();
        ev.action = act;
        ev.ack_received = 1'b1;
        ev.arbitration_lost = 1'b0;
        return ev;
    endfunction

    // A controller event that now and then carries a NACK, a lost arbitration or a stray code.
    function automatic t_event noisy_event(input logic [2:0] act);
        t_event ev;
        ev = clean_event(act);
        if ($urandom_range(0, 39) == 0) ev.ack_received = 1'b0;
        if ($urandom_range(0, 59) == 0) ev.arbitration_lost = 1'b1;
        if ($urandom_range(0, 59) == 0) ev.action = 3'($urandom_range(0, 7));
        return ev;
    endfunction

    // Queues one complete transfer as the byte-level controller would report it.
    task automatic queue_transfer();
        t_event      ev;
        logic        rd;
        logic [7:0]  dev;
        logic [15:0] len;
        int          moved;
        int          offset_events;
        rd = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0: dev = wide_cfg.wide_one;
            1: dev = wide_cfg.wide_two;
            2: dev = wide_cfg.wide_three;
            3: dev = wide_cfg.wide_one ^ 8'h01;
            default: dev = 8'($urandom);
        endcase
        if ($urandom_range(0, 29) == 0) begin
            len = 16'd0;
        end else if ($urandom_range(0, 14) == 0) begin
            len = 16'($urandom);
        end else begin
            len = 16'($urandom_range(1, 6));
        end
        // Long transfers are cut short and then mostly aborted.
        moved = (len > 16'd8) ? int'($urandom_range(1, 8)) : int'(len);
        offset_events = is_wide(dev) ? 2 : 1;
        ev = clean_event(rd ? ACT_READ : ACT_WRITE);
        ev.device_address = dev;
        ev.transfer_length = len;
        pending_events.push_back(ev);
        pending_events.push_back(noisy_event(ACT_START_SENT));
        repeat (offset_events) pending_events.push_back(noisy_event(ACT_BYTE_SENT));
        if (rd) begin
            pending_events.push_back(noisy_event(ACT_BYTE_SENT));
            pending_events.push_back(noisy_event(ACT_START_SENT));
            pending_events.push_back(noisy_event(ACT_BYTE_SENT));
            repeat (moved) pending_events.push_back(noisy_event(ACT_BYTE_RECEIVED));
        end else begin
            repeat (moved) pending_events.push_back(noisy_event(ACT_BYTE_SENT));
            if (moved == int'(len)) pending_events.push_back(noisy_event(ACT_BYTE_SENT));
        end
        if (moved != int'(len) && $urandom_range(0, 3) != 0) begin
            pending_events.push_back(clean_event(ACT_RESET));
        end
    endtask

    task automatic queue_phase(input int count);
        @(posedge i_clk);
        while (pending_events.size() < count) begin
            if ($urandom_range(0, 9) == 0) begin
                pending_events.push_back(random_event());
            end else begin
                queue_transfer();
            end
        end
    endtask

    task automatic write_wide_cfg(input t_cfg_index idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_WIDE_DEVICE_ONE: wide_cfg.wide_one = value;
            CFG_WIDE_DEVICE_TWO: wide_cfg.wide_two = value;
            default: wide_cfg.wide_three = value;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every request is in and every result is out, then lets the pipeline settle.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_events.size() != 0 || i_in_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Driver: presents queued requests, with a drawn gap after each accepted one.
    always @(negedge i_clk) begin
        t_event ev;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || event_taken) begin
            event_taken = 1'b0;
            if (send_wait > 0) begin
                send_wait = send_wait - 1;
                i_in_valid <= 1'b0;
            end else if (pending_events.size() > 0) begin
                ev = pending_events.pop_front();
                i_action <= ev.action;
                i_device_address <= ev.device_address;
                i_offset_address <= ev.offset_address;
                i_transfer_length <= ev.transfer_length;
                i_ack_received <= ev.ack_received;
                i_arbitration_lost <= ev.arbitration_lost;
                i_received_byte <= ev.received_byte;
                i_next_write_byte <= ev.next_write_byte;
                i_in_valid <= 1'b1;
                if ($urandom_range(0, 39) == 0) send_mode = $urandom_range(0, 2);
                send_wait = pick_wait(send_mode);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result side stall: the long hold-off wins over the per-result stall.
    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // One long hold-off on the result side while requests keep coming.
    always @(posedge i_clk) begin
        if (hold_off_left > 0) begin
            hold_off_left = hold_off_left - 1;
        end else if (!hold_off_done && results_seen >= HOLD_OFF_AT) begin
            hold_off_left = HOLD_OFF_CYCLES;
            hold_off_done = 1'b1;
        end
    end

    // Monitor: predicts each accepted request and checks each accepted result.
    always @(posedge i_clk) begin
        t_event  taken;
        t_result seen;
        t_result want;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            taken.action = i_action;
            taken.device_address = i_device_address;
            taken.offset_address = i_offset_address;
            taken.transfer_length = i_transfer_length;
            taken.ack_received = i_ack_received;
            taken.arbitration_lost = i_arbitration_lost;
            taken.received_byte = i_received_byte;
            taken.next_write_byte = i_next_write_byte;
            expected_results.push_back(sequence_event(taken));
            event_taken = 1'b1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen <= results_seen + 1;
            if ($urandom_range(0, 39) == 0) recv_mode = $urandom_range(0, 2);
            stall_left = pick_wait(recv_mode);
            if (expected_results.size() == 0) begin
                $error("result arrived with no request outstanding");
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                seen.transmit_valid = o_transmit_valid;
                seen.transmit_byte = o_transmit_byte;
                seen.issue_start = o_issue_start;
                seen.issue_stop = o_issue_stop;
                seen.ack_to_send = o_ack_to_send;
                seen.store_valid = o_store_valid;
                seen.store_byte = o_store_byte;
                seen.data_index = o_data_index;
                seen.busy_now = o_busy_now;
                seen.transfer_failed = o_transfer_failed;
                seen.request_rejected = o_request_rejected;
                check_field("transmit_valid", 16'(want.transmit_valid),
                            16'(seen.transmit_valid));
                check_field("transmit_byte", 16'(want.transmit_byte),
                            16'(seen.transmit_byte));
                check_field("issue_start", 16'(want.issue_start), 16'(seen.issue_start));
                check_field("issue_stop", 16'(want.issue_stop), 16'(seen.issue_stop));
                check_field("ack_to_send", 16'(want.ack_to_send), 16'(seen.ack_to_send));
                check_field("store_valid", 16'(want.store_valid), 16'(seen.store_valid));
                check_field("store_byte", 16'(want.store_byte), 16'(seen.store_byte));
                check_field("data_index", want.data_index, seen.data_index);
                check_field("busy_now", 16'(want.busy_now), 16'(seen.busy_now));
                check_field("transfer_failed", 16'(want.transfer_failed),
                            16'(seen.transfer_failed));
                check_field("request_rejected", 16'(want.request_rejected),
                            16'(seen.request_rejected));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Sequence of the run: reset, directed requests, then random phases with fresh settings.
    initial begin
        t_event ev;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero length, a wide-offset read of two bytes and a request made while busy.
        ev = clean_event(ACT_WRITE);
        ev.transfer_length = 16'd0;
        pending_events.push_back(ev);
        ev = clean_event(ACT_READ);
        ev.device_address = 8'h00;
        ev.offset_address = 16'hFFFF;
        ev.transfer_length = 16'd2;
        pending_events.push_back(ev);
        ev = clean_event(ACT_WRITE);
        ev.transfer_length = 16'd5;
        pending_events.push_back(ev);
        pending_events.push_back(clean_event(ACT_START_SENT));
        repeat (3) pending_events.push_back(clean_event(ACT_BYTE_SENT));
        pending_events.push_back(clean_event(ACT_START_SENT));
        pending_events.push_back(clean_event(ACT_BYTE_SENT));
        ev = clean_event(ACT_BYTE_RECEIVED);
        ev.received_byte = 8'hFF;
        pending_events.push_back(ev);
        ev = clean_event(ACT_BYTE_RECEIVED);
        ev.received_byte = 8'h00;
        pending_events.push_back(ev);

        // A request ignores the flags; a NACK on the address restarts the write.
        ev = clean_event(ACT_WRITE);
        ev.device_address = 8'hFF;
        ev.offset_address = 16'h0000;
        ev.transfer_length = 16'hFFFF;
        ev.ack_received = 1'b0;
        ev.arbitration_lost = 1'b1;
        pending_events.push_back(ev);
        pending_events.push_back(clean_event(ACT_START_SENT));
        ev = clean_event(ACT_BYTE_SENT);
        ev.ack_received = 1'b0;
        pending_events.push_back(ev);
        pending_events.push_back(clean_event(ACT_START_SENT));
        pending_events.push_back(clean_event(ACT_BYTE_SENT));
        ev = clean_event(ACT_BYTE_SENT);
        ev.next_write_byte = 8'hFF;
        pending_events.push_back(ev);
        ev = clean_event(ACT_BYTE_SENT);
        ev.next_write_byte = 8'h00;
        pending_events.push_back(ev);

        // Failures: unknown status, NACK once disarmed, lost arbitration, stray code, reset.
        pending_events.push_back(clean_event(ACT_OTHER_STATUS));
        ev = clean_event(ACT_BYTE_SENT);
        ev.ack_received = 1'b0;
        pending_events.push_back(ev);
        ev = clean_event(ACT_READ);
        ev.device_address = 8'h12;
        ev.transfer_length = 16'd1;
        pending_events.push_back(ev);
        ev = clean_event(ACT_START_SENT);
        ev.arbitration_lost = 1'b1;
        pending_events.push_back(ev);
        pending_events.push_back(clean_event(ACT_UNKNOWN_STATUS));
        pending_events.push_back(clean_event(ACT_RESET));
        ev = clean_event(ACT_BYTE_RECEIVED);
        ev.received_byte = 8'hA5;
        pending_events.push_back(ev);
        wait_drained();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase == 1) begin
                write_wide_cfg(CFG_WIDE_DEVICE_ONE, 8'hFF);
                write_wide_cfg(CFG_WIDE_DEVICE_TWO, 8'hFF);
                write_wide_cfg(CFG_WIDE_DEVICE_THREE, 8'hFF);
            end else if (phase == 2) begin
                write_wide_cfg(CFG_WIDE_DEVICE_ONE, 8'h00);
                write_wide_cfg(CFG_WIDE_DEVICE_TWO, 8'h00);
                write_wide_cfg(CFG_WIDE_DEVICE_THREE, 8'h00);
            end else if (phase > 2) begin
                write_wide_cfg(CFG_WIDE_DEVICE_ONE, 8'($urandom));
                write_wide_cfg(CFG_WIDE_DEVICE_TWO, 8'($urandom));
                write_wide_cfg(CFG_WIDE_DEVICE_THREE, 8'($urandom));
            end
            queue_phase(PHASE_REQUESTS);
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
